[rtl/core/clipped_line_span_raster_defines.svh]
// assertion macros for the checker file of the span raster
`ifndef CLIPPED_LINE_SPAN_RASTER_DEFINES_SVH
`define CLIPPED_LINE_SPAN_RASTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define CLSR_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define CLSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/clsr_pkg.sv]
// types, constants and helpers of the clipped line span raster
package clsr_pkg;

	localparam int COORD_BITS     = 16;
	localparam int CFG_BITS       = 16;
	localparam int CFG_IDX_BITS   = 3;
	localparam int DIM_BITS       = 13;
	localparam int MAX_TARGET_DIM = 4096;
	localparam int ADDR_BITS      = 25;
	localparam int COLOUR_BITS    = 8;
	localparam int DELTA_BITS     = COORD_BITS + 1;
	localparam int RUN_BITS       = COORD_BITS + 1;
	localparam int ERR_BITS       = COORD_BITS + 2;
	localparam int OFS_BITS       = COORD_BITS + 3;
	localparam int PROD_BITS      = 2 * DIM_BITS + 1;
	localparam int QUEUE_DEPTH    = 4;

	// command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_LEFT   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_TOP    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROW_PAD       = 3'd4;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [COORD_BITS:0]   wide_t;
	typedef logic        [DELTA_BITS-1:0] delta_t;
	typedef logic        [RUN_BITS-1:0]   run_t;
	typedef logic signed [ERR_BITS-1:0]   err_t;
	typedef logic signed [OFS_BITS-1:0]   ofs_t;
	typedef logic        [DIM_BITS-1:0]   dim_t;
	typedef logic        [COLOUR_BITS-1:0] colour_t;

	typedef struct packed {
		logic    command;
		coord_t  start_x;
		coord_t  start_y;
		coord_t  end_x;
		coord_t  end_y;
		colour_t line_colour;
	} cmd_item_t;

	typedef struct packed {
		logic                 span_visible;
		logic [ADDR_BITS-1:0] span_address;
		dim_t                 span_length;
		colour_t              span_colour;
		logic                 line_finished;
		logic                 last_in_run;
	} res_item_t;

	typedef struct packed {
		logic signed [CFG_BITS-1:0] target_left;
		logic signed [CFG_BITS-1:0] target_top;
		dim_t                       target_width;
		dim_t                       target_height;
		dim_t                       row_pad;
	} cfg_t;

	// one span request in screen coordinates, or a blank result
	typedef struct packed {
		logic   valid;
		coord_t sx;
		coord_t sy;
		run_t   len;
	} span_req_t;

	// everything the back end needs for the results of one command
	typedef struct packed {
		span_req_t span0;
		span_req_t span1;
		logic      two;
		colour_t   colour;
		logic      finished;
	} q_entry_t;

	// window dimension saturated to the largest supported size
	function automatic dim_t dim_sat(input dim_t v);
		dim_sat = (int'(v) > MAX_TARGET_DIM) ? dim_t'(MAX_TARGET_DIM) : v;
	endfunction

endpackage

[rtl/core/clsr_front.sv]
// front end: takes commands, keeps the line state, queues span requests
module clsr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  clsr_pkg::cmd_item_t cmd,
	input  clsr_pkg::cfg_t      cfg,
	input  logic                q_ready,
	output logic                push,
	output clsr_pkg::q_entry_t  push_entry
);
	import clsr_pkg::*;

	function automatic delta_t absd(input coord_t a, input coord_t b);
		wide_t d;
		d = wide_t'(a) - wide_t'(b);
		absd = delta_t'(d[COORD_BITS] ? -d : d);
	endfunction

	logic    active_q, steep_q, down_q;
	coord_t  major_pos_q, major_end_q, minor_pos_q, run_start_q;
	run_t    run_len_q;
	err_t    err_q;
	delta_t  maj_d_q, min_d_q;
	colour_t colour_q;

	// load path
	dim_t    w, h;
	coord_t  ax, ay, bx, by;
	coord_t  max_x, min_x, max_y, min_y;
	logic signed [CFG_BITS-1:0] cfg_left, cfg_top;
	ofs_t    left_e, right_e, top_e, bottom_e;
	logic    reject, steep, swap, zero_len;
	delta_t  dx, dy, ld_maj_d, ld_min_d;
	coord_t  j0, n0, j1, n1, lj0, ln0, lj1, ln1;
	wide_t   ld_diff;

	// step path
	wide_t   pos_inc;
	logic    last, neg;
	err_t    e1, e2;
	coord_t  minor_next, rs_next;
	run_t    rl_pend;
	span_req_t span_n, span_l, span_blank;

	assign cmd_ready = q_ready;
	assign push      = cmd_valid && q_ready;

	always_comb begin
		w        = dim_sat(cfg.target_width);
		h        = dim_sat(cfg.target_height);
		ax       = cmd.start_x;
		ay       = cmd.start_y;
		bx       = cmd.end_x;
		by       = cmd.end_y;
		cfg_left = cfg.target_left;
		cfg_top  = cfg.target_top;
		max_x    = (ax > bx) ? ax : bx;
		min_x    = (ax < bx) ? ax : bx;
		max_y    = (ay > by) ? ay : by;
		min_y    = (ay < by) ? ay : by;
		left_e   = ofs_t'(cfg_left);
		top_e    = ofs_t'(cfg_top);
		right_e  = left_e + ofs_t'({1'b0, w});
		bottom_e = top_e + ofs_t'({1'b0, h});
		// bounding box against the window
		reject   = (w == '0) || (h == '0)
			|| (ofs_t'(max_x) < left_e) || (ofs_t'(min_x) >= right_e)
			|| (ofs_t'(max_y) < top_e) || (ofs_t'(min_y) >= bottom_e);
		dx       = absd(ax, bx);
		dy       = absd(ay, by);
		steep    = dy > dx;
		j0       = steep ? ay : ax;
		n0       = steep ? ax : ay;
		j1       = steep ? by : bx;
		n1       = steep ? bx : by;
		swap     = j0 > j1;
		lj0      = swap ? j1 : j0;
		ln0      = swap ? n1 : n0;
		lj1      = swap ? j0 : j1;
		ln1      = swap ? n0 : n1;
		zero_len = lj0 == lj1;
		ld_diff  = wide_t'(lj1) - wide_t'(lj0);
		ld_maj_d = delta_t'(ld_diff);
		ld_min_d = absd(ln0, ln1);
	end

	always_comb begin
		pos_inc    = wide_t'(major_pos_q) + wide_t'(1);
		last       = pos_inc == wide_t'(major_end_q);
		e1         = err_q - err_t'({1'b0, min_d_q});
		neg        = e1[ERR_BITS-1];
		e2         = neg ? (e1 + err_t'({1'b0, maj_d_q})) : e1;
		minor_next = minor_pos_q;
		if (neg) begin
			minor_next = down_q ? (minor_pos_q - coord_t'(1)) : (minor_pos_q + coord_t'(1));
		end
		rs_next    = neg ? coord_t'(pos_inc[COORD_BITS-1:0]) : run_start_q;
		rl_pend    = neg ? '0 : run_len_q;
		span_blank = '0;
		span_n     = '{valid: 1'b1, sx: run_start_q, sy: minor_pos_q, len: run_len_q};
		span_l     = '{valid: 1'b1, sx: rs_next, sy: minor_next, len: rl_pend};
	end

	always_comb begin
		push_entry        = '0;
		push_entry.colour = colour_q;
		if (cmd.command == CMD_LOAD) begin
			push_entry.colour   = cmd.line_colour;
			push_entry.finished = reject || zero_len;
		end else if (!active_q) begin
			push_entry.finished = 1'b1;
		end else begin
			push_entry.finished = last;
			if (steep_q) begin
				push_entry.span0 = '{valid: 1'b1, sx: minor_pos_q, sy: major_pos_q,
					len: run_t'(1)};
			end else if (neg && last) begin
				push_entry.span0 = span_n;
				push_entry.span1 = span_l;
				push_entry.two   = 1'b1;
			end else if (neg) begin
				push_entry.span0 = span_n;
			end else if (last) begin
				push_entry.span0 = span_l;
			end else begin
				push_entry.span0 = span_blank;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (push) begin
			if (cmd.command == CMD_LOAD) begin
				active_q <= !(reject || zero_len);
			end else if (active_q && last) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (cmd.command == CMD_LOAD) begin
				colour_q    <= cmd.line_colour;
				steep_q     <= steep;
				major_pos_q <= lj0;
				major_end_q <= lj1;
				minor_pos_q <= ln0;
				maj_d_q     <= ld_maj_d;
				min_d_q     <= ld_min_d;
				down_q      <= !(ln0 < ln1);
				err_q       <= err_t'({1'b0, ld_maj_d[DELTA_BITS-1:1]});
				run_start_q <= lj0;
				run_len_q   <= run_t'(1);
			end else if (active_q) begin
				err_q       <= e2;
				minor_pos_q <= minor_next;
				run_start_q <= rs_next;
				run_len_q   <= rl_pend + run_t'(1);
				major_pos_q <= coord_t'(pos_inc[COORD_BITS-1:0]);
			end
		end
	end

endmodule

[rtl/core/clsr_queue.sv]
// short queue of span requests between front and back end
module clsr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  clsr_pkg::q_entry_t push_entry,
	output logic               ready,
	output logic               valid,
	output clsr_pkg::q_entry_t head,
	input  logic               pop
);
	import clsr_pkg::*;

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	q_entry_t            mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] cnt_q;

	assign ready = cnt_q != CNT_BITS'(QUEUE_DEPTH);
	assign valid = cnt_q != '0;
	assign head  = mem_q[rd_ptr_q];

	// depth is a power of two, pointers wrap on their own
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_BITS'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

[rtl/core/clsr_back.sv]
// back end: clips span requests, forms byte offsets, drives results
module clsr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  clsr_pkg::q_entry_t  q_head,
	output logic                pop,
	input  clsr_pkg::cfg_t      cfg,
	output logic                res_valid,
	input  logic                res_ready,
	output clsr_pkg::res_item_t res
);
	import clsr_pkg::*;

	logic      adv, take, sub_q;
	span_req_t req;
	dim_t      w, h;
	logic [DIM_BITS:0] wp;
	logic signed [CFG_BITS-1:0] cfg_left, cfg_top;
	ofs_t      ox, oy, len0;
	logic      vis;

	logic      valid_s1, vis_s1, fin_s1, last_s1;
	ofs_t      ox_s1, len_s1;
	dim_t      oy_s1;
	colour_t   colour_s1;

	ofs_t      lsum, len_a, ox_a;
	logic      left_cut, vis_a;
	logic [PROD_BITS-1:0] prod;

	logic      valid_s2, vis_s2, fin_s2, last_s2;
	ofs_t      ox_s2, len_s2;
	logic [PROD_BITS-1:0] prod_s2;
	colour_t   colour_s2;

	ofs_t      rsum, len_b;
	logic      over, vis_b;
	logic [ADDR_BITS-1:0] addr;

	logic      valid_s3;
	res_item_t res_s3;

	assign adv       = !valid_s3 || res_ready;
	assign take      = adv && q_valid;
	assign pop       = take && (!q_head.two || sub_q);
	assign res_valid = valid_s3;
	assign res       = res_s3;

	always_comb begin
		w        = dim_sat(cfg.target_width);
		h        = dim_sat(cfg.target_height);
		wp       = {1'b0, w} + {1'b0, cfg.row_pad};
		cfg_left = cfg.target_left;
		cfg_top  = cfg.target_top;
		req      = sub_q ? q_head.span1 : q_head.span0;
		ox       = ofs_t'(req.sx) - ofs_t'(cfg_left);
		oy       = ofs_t'(req.sy) - ofs_t'(cfg_top);
		len0     = (req.len == '0) ? ofs_t'(1) : ofs_t'({1'b0, req.len});
		vis      = req.valid && !oy[OFS_BITS-1] && (oy < ofs_t'({1'b0, h}));
	end

	// left edge clip and row base
	always_comb begin
		left_cut = ox_s1[OFS_BITS-1];
		lsum     = len_s1 + ox_s1;
		len_a    = left_cut ? lsum : len_s1;
		ox_a     = left_cut ? '0 : ox_s1;
		vis_a    = vis_s1 && !(left_cut && (lsum <= ofs_t'(0)));
		prod     = PROD_BITS'(oy_s1) * PROD_BITS'(wp);
	end

	// right edge clip and final offset
	always_comb begin
		rsum  = ox_s2 + len_s2;
		over  = rsum > ofs_t'({1'b0, w});
		len_b = over ? (ofs_t'({1'b0, w}) - ox_s2) : len_s2;
		vis_b = vis_s2 && !(over && (len_b <= ofs_t'(0)));
		addr  = prod_s2[ADDR_BITS-1:0] + ADDR_BITS'(ox_s2[DIM_BITS-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q    <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			if (take) begin
				sub_q <= q_head.two && !sub_q;
			end
			valid_s1 <= q_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_s1    <= vis;
			ox_s1     <= ox;
			oy_s1     <= oy[DIM_BITS-1:0];
			len_s1    <= len0;
			colour_s1 <= q_head.colour;
			fin_s1    <= q_head.finished;
			last_s1   <= !q_head.two || sub_q;

			vis_s2    <= vis_a;
			ox_s2     <= ox_a;
			len_s2    <= len_a;
			prod_s2   <= prod;
			colour_s2 <= colour_s1;
			fin_s2    <= fin_s1;
			last_s2   <= last_s1;

			res_s3.span_visible  <= vis_b;
			res_s3.span_address  <= vis_b ? addr : '0;
			res_s3.span_length   <= vis_b ? len_b[DIM_BITS-1:0] : '0;
			res_s3.span_colour   <= vis_b ? colour_s2 : '0;
			res_s3.line_finished <= fin_s2;
			res_s3.last_in_run   <= last_s2;
		end
	end

endmodule

[rtl/core/clipped_line_span_raster.sv]
// a command transfer is queued, then moves through s1, s2 and the result
// register; the second result of a two-span command follows the first
// throughput: one command per cycle while the queue has room, one result per
// cycle out of the back end while res_ready is high, each span a result of its own
// reset: arst_n clears the active line, the queue and the pipeline valids and
// sets the window to left 0, top 0, width 640, height 480, pad 0
module clipped_line_span_raster (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cmd_valid,
	output logic                                  cmd_ready,
	input  clsr_pkg::cmd_item_t                   cmd,
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output clsr_pkg::res_item_t                   res,
	input  logic                                  cfg_we,
	input  logic [clsr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [clsr_pkg::CFG_BITS-1:0]         cfg_data
);
	import clsr_pkg::*;

	// window registers; user writes only while no command is in flight, not enforced
	cfg_t     cfg_q;

	// front to queue
	logic     push, q_ready;
	q_entry_t push_entry;

	// queue to back end
	logic     q_valid, pop;
	q_entry_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_left   <= '0;
			cfg_q.target_top    <= '0;
			cfg_q.target_width  <= dim_t'(640);
			cfg_q.target_height <= dim_t'(480);
			cfg_q.row_pad       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET_LEFT: begin
					cfg_q.target_left <= cfg_data;
				end
				REG_TARGET_TOP: begin
					cfg_q.target_top <= cfg_data;
				end
				REG_TARGET_WIDTH: begin
					cfg_q.target_width <= cfg_data[DIM_BITS-1:0];
				end
				REG_TARGET_HEIGHT: begin
					cfg_q.target_height <= cfg_data[DIM_BITS-1:0];
				end
				REG_ROW_PAD: begin
					cfg_q.row_pad <= cfg_data[DIM_BITS-1:0];
				end
				default: begin
					// unused index, write dropped
				end
			endcase
		end
	end

	// front end: one command per cycle while the queue has room; loads and Bresenham
	// steps settle in the cycle of the transfer and leave a request in the queue
	clsr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd),
		.cfg        (cfg_q),
		.q_ready    (q_ready),
		.push       (push),
		.push_entry (push_entry)
	);

	// decouples the front end from a stalled result port
	clsr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.ready      (q_ready),
		.valid      (q_valid),
		.head       (q_head),
		.pop        (pop)
	);

	// back end: three stages, clip start, left clip with row multiply,
	// right clip with offset add into the result register
	clsr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.pop       (pop),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

[rtl/core/clsr_checker.sv]
// port level checks of the span raster and their bind
`include "clipped_line_span_raster_defines.svh"

module clsr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                res_valid,
	input logic                res_ready,
	input clsr_pkg::res_item_t res
);
	import clsr_pkg::*;

	`CLSR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result changed while stalled")
	`CLSR_ASSERT_SAME(a_blank_zero, res_valid && !res.span_visible, res.span_address == '0 && res.span_length == '0 && res.span_colour == '0, "blank result carries span data")
	`CLSR_ASSERT_SAME(a_len_nonzero, res_valid && res.span_visible, res.span_length != '0, "visible span of zero length")
	`CLSR_ASSERT_NEXT(a_pair_adjacent, res_valid && res_ready && !res.last_in_run, res_valid && res.line_finished == $past(res.line_finished), "second result of a command missing or inconsistent")

endmodule

bind clipped_line_span_raster clsr_checker u_clsr_checker (.*);

[tb/sv/tb_top.sv]
// testbench for the clipped line span raster: directed and random lines checked by a predictor
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import clsr_pkg::*;

	// receiver stall styles, picked at random by the result receiver
	typedef enum int {RX_OPEN, RX_CHOPPY, RX_STALLS} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_item_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_item_t res;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_BITS-1:0] cfg_data = '0;

	clipped_line_span_raster u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// commands waiting for the driver, spans waiting for the dut
	cmd_item_t pending_cmds[$];
	res_item_t expected_spans[$];
	int fault_count = 0;

	// window registers as the predictor sees them
	logic signed [CFG_BITS-1:0] win_left = '0;
	logic signed [CFG_BITS-1:0] win_top = '0;
	dim_t win_w = dim_t'(640);
	dim_t win_h = dim_t'(480);
	dim_t win_pad = '0;

	// line walker state of the predictor
	bit tracing = 1'b0;
	bit transposed = 1'b0;
	bit row_dec = 1'b0;
	coord_t col_pos = '0;
	coord_t col_last = '0;
	coord_t row_pos = '0;
	coord_t seg_start = '0;
	run_t seg_len = '0;
	err_t bres_err = '0;
	delta_t span_major = '0;
	delta_t span_minor = '0;
	colour_t ink = '0;

	// handshake bookkeeping between the clocked blocks
	bit cmd_fire = 1'b0;
	int gap_left = 0;
	int burst_left = 16;
	int hold_left = 0;
	int rx_cycle = 0;
	rx_mode_t rx_mode = RX_OPEN;

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int mag(input int v);
		return (v < 0) ? -v : v;
	endfunction

	// window size with anything past the largest supported size pulled back
	function automatic int sat_dim(input dim_t v);
		return (int'(v) > MAX_TARGET_DIM) ? MAX_TARGET_DIM : int'(v);
	endfunction

	function automatic int clamp_coord(input int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// one span clipped to the window; stays blank when nothing is left of it
	function automatic void clip_span(input int sx, input int sy, input int len,
		output res_item_t r);
		int w;
		int h;
		int ox;
		int oy;
		longint ofs;
		r = '0;
		w = sat_dim(win_w);
		h = sat_dim(win_h);
		ox = sx - int'(win_left);
		oy = sy - int'(win_top);
		if (oy < 0 || oy >= h)
			return;
		// a run that never grew still paints one pixel
		if (len == 0)
			len = 1;
		if (ox < 0) begin
			len += ox;
			if (len <= 0)
				return;
			ox = 0;
		end
		if (ox + len > w) begin
			len = w - ox;
			if (len <= 0)
				return;
		end
		ofs = longint'(oy) * longint'(w + int'(win_pad)) + longint'(ox);
		r.span_visible = 1'b1;
		r.span_address = ofs[ADDR_BITS-1:0];
		r.span_length = len[DIM_BITS-1:0];
		r.span_colour = ink;
	endfunction

	// new line: window reject, transpose steep lines, order along the major axis
	function automatic void raster_load(input cmd_item_t c);
		int ax;
		int ay;
		int bx;
		int by;
		int w;
		int h;
		int j0;
		int n0;
		int j1;
		int n1;
		int t;
		ax = int'(c.start_x);
		ay = int'(c.start_y);
		bx = int'(c.end_x);
		by = int'(c.end_y);
		w = sat_dim(win_w);
		h = sat_dim(win_h);
		ink = c.line_colour;
		tracing = 1'b0;
		if (w == 0 || h == 0)
			return;
		if ((ax > bx ? ax : bx) < int'(win_left) || (ax < bx ? ax : bx) >= int'(win_left) + w)
			return;
		if ((ay > by ? ay : by) < int'(win_top) || (ay < by ? ay : by) >= int'(win_top) + h)
			return;
		transposed = mag(ay - by) > mag(ax - bx);
		if (transposed) begin
			j0 = ay; n0 = ax; j1 = by; n1 = bx;
		end else begin
			j0 = ax; n0 = ay; j1 = bx; n1 = by;
		end
		if (j0 > j1) begin
			t = j0; j0 = j1; j1 = t;
			t = n0; n0 = n1; n1 = t;
		end
		// no length along the major axis: nothing to walk
		if (j0 == j1)
			return;
		col_pos = coord_t'(j0);
		col_last = coord_t'(j1);
		row_pos = coord_t'(n0);
		span_major = delta_t'(j1 - j0);
		span_minor = delta_t'(mag(n0 - n1));
		row_dec = !(n0 < n1);
		bres_err = err_t'((j1 - j0) / 2);
		seg_start = coord_t'(j0);
		seg_len = run_t'(1);
		tracing = 1'b1;
	endfunction

	// expected spans of one accepted command, appended in order
	function automatic void predict_transfer(input cmd_item_t c);
		res_item_t outs[$];
		res_item_t r;
		bit at_end;
		int e;
		if (c.command == CMD_LOAD) begin
			raster_load(c);
		end else if (tracing) begin
			at_end = (int'(col_pos) + 1 == int'(col_last));
			// steep lines paint a single pixel per row
			if (transposed) begin
				clip_span(int'(row_pos), int'(col_pos), 1, r);
				outs.push_back(r);
			end
			e = int'(bres_err) - int'(span_minor);
			if (e < 0) begin
				// minor axis moves: flush the run that was building up
				if (!transposed) begin
					clip_span(int'(seg_start), int'(row_pos), int'(seg_len), r);
					outs.push_back(r);
				end
				seg_start = coord_t'(int'(col_pos) + 1);
				seg_len = '0;
				row_pos = coord_t'(int'(row_pos) + (row_dec ? -1 : 1));
				e += int'(span_major);
			end
			bres_err = err_t'(e);
			// last column flushes the open run again
			if (at_end && !transposed) begin
				clip_span(int'(seg_start), int'(row_pos), int'(seg_len), r);
				outs.push_back(r);
			end
			col_pos = coord_t'(int'(col_pos) + 1);
			seg_len = seg_len + 1'b1;
			if (at_end)
				tracing = 1'b0;
		end
		if (outs.size() == 0)
			outs.push_back('0);
		foreach (outs[k]) begin
			outs[k].line_finished = !tracing;
			outs[k].last_in_run = (k == outs.size() - 1);
			expected_spans.push_back(outs[k]);
		end
	endfunction

	// every field random; steps ignore all but the command bit
	function automatic cmd_item_t junk_item(input logic kind);
		cmd_item_t c;
		c.command = kind;
		c.start_x = coord_t'($urandom);
		c.start_y = coord_t'($urandom);
		c.end_x = coord_t'($urandom);
		c.end_y = coord_t'($urandom);
		c.line_colour = colour_t'($urandom);
		return c;
	endfunction

	function automatic void queue_line(input int ax, input int ay, input int bx, input int by,
		input int colour, input int steps);
		cmd_item_t c;
		c.command = CMD_LOAD;
		c.start_x = coord_t'(ax);
		c.start_y = coord_t'(ay);
		c.end_x = coord_t'(bx);
		c.end_y = coord_t'(by);
		c.line_colour = colour_t'(colour);
		pending_cmds.push_back(c);
		repeat (steps)
			pending_cmds.push_back(junk_item(CMD_STEP));
	endfunction

	// a coordinate near the window edge half the time, anywhere across it otherwise
	function automatic int near_coord(input int origin, input int extent);
		int off;
		if ($urandom_range(0, 1))
			off = int'($urandom_range(0, ((extent < 64) ? extent : 64) + 16));
		else
			off = int'($urandom_range(0, extent + 16));
		return clamp_coord(origin - 8 + off);
	endfunction

	// mostly lines that touch the window, walked to or past their end
	task automatic fill_random(input int n);
		int made;
		int sel;
		int ax;
		int ay;
		int bx;
		int by;
		int reach;
		int major;
		int steps;
		made = 0;
		while (made < n) begin
			sel = $urandom_range(0, 99);
			if (sel < 8) begin
				pending_cmds.push_back(junk_item(CMD_STEP));
				made++;
			end else if (sel < 16) begin
				// full-range endpoints, mostly rejected
				steps = $urandom_range(0, 3);
				pending_cmds.push_back(junk_item(CMD_LOAD));
				repeat (steps)
					pending_cmds.push_back(junk_item(CMD_STEP));
				made += 1 + steps;
			end else begin
				reach = ($urandom_range(0, 9) == 0) ? 300 : 12;
				ax = near_coord(int'(win_left), sat_dim(win_w));
				ay = near_coord(int'(win_top), sat_dim(win_h));
				bx = clamp_coord(ax + int'($urandom_range(0, 2 * reach)) - reach);
				by = clamp_coord(ay + int'($urandom_range(0, 2 * reach)) - reach);
				major = (mag(bx - ax) > mag(by - ay)) ? mag(bx - ax) : mag(by - ay);
				// now and then a line is cut short by the next load
				if ($urandom_range(0, 7) == 0)
					steps = $urandom_range(0, major);
				else
					steps = major + $urandom_range(0, 2);
				queue_line(ax, ay, bx, by, $urandom_range(0, 255), steps);
				made += 1 + steps;
			end
		end
	endtask

	// wait until the block has nothing left in flight
	task automatic drain;
		while (pending_cmds.size() != 0 || cmd_valid || expected_spans.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// register write, mirrored into the predictor while the block is idle
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
		input logic [CFG_BITS-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_TARGET_LEFT: win_left = data;
			REG_TARGET_TOP: win_top = data;
			REG_TARGET_WIDTH: win_w = dim_t'(data);
			REG_TARGET_HEIGHT: win_h = dim_t'(data);
			REG_ROW_PAD: win_pad = dim_t'(data);
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input int left, input int top, input int w, input int h,
		input int pad, input int n);
		write_reg(REG_TARGET_LEFT, CFG_BITS'(left));
		write_reg(REG_TARGET_TOP, CFG_BITS'(top));
		write_reg(REG_TARGET_WIDTH, CFG_BITS'(w));
		write_reg(REG_TARGET_HEIGHT, CFG_BITS'(h));
		write_reg(REG_ROW_PAD, CFG_BITS'(pad));
		fill_random(n);
		drain();
	endtask

	// command driver: bursts of transfers with random gaps between them
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (!cmd_valid || cmd_fire) begin
			if (gap_left > 0) begin
				gap_left--;
				cmd_valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				cmd <= pending_cmds.pop_front();
				cmd_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 48);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// result receiver: open, choppy or long stalls, the mode picked anew at random
	always @(negedge clk) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			rx_cycle++;
			if (rx_cycle % 200 == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 2));
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_OPEN: res_ready <= 1'b1;
					RX_CHOPPY: res_ready <= 1'($urandom_range(0, 1));
					default: begin
						res_ready <= 1'b1;
						if ($urandom_range(0, 11) == 0)
							hold_left = $urandom_range(1, 20);
					end
				endcase
			end
		end
	end

	// predict on each command transfer, check each result transfer in order
	always @(posedge clk) begin : monitor
		res_item_t want;
		cmd_fire = arst_n && cmd_valid && cmd_ready;
		if (cmd_fire)
			predict_transfer(cmd);
		if (arst_n && res_valid && res_ready) begin
			if (expected_spans.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("extra result vis=%0d addr=%h len=%0d col=%0d fin=%0d last=%0d",
						res.span_visible, res.span_address, res.span_length,
						res.span_colour, res.line_finished, res.last_in_run);
			end else begin
				want = expected_spans.pop_front();
				if (res.span_visible !== want.span_visible
					|| res.span_address !== want.span_address
					|| res.span_length !== want.span_length
					|| res.span_colour !== want.span_colour
					|| res.line_finished !== want.line_finished
					|| res.last_in_run !== want.last_in_run) begin
					fault_count++;
					if (fault_count <= 10) begin
						$display("span mismatch at %0t", $realtime);
						$display("  want vis=%0d addr=%h len=%0d col=%0d fin=%0d last=%0d",
							want.span_visible, want.span_address, want.span_length,
							want.span_colour, want.line_finished, want.last_in_run);
						$display("  got  vis=%0d addr=%h len=%0d col=%0d fin=%0d last=%0d",
							res.span_visible, res.span_address, res.span_length,
							res.span_colour, res.line_finished, res.last_in_run);
					end
				end
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed lines on the reset window 640x480 at the origin
		pending_cmds.push_back(junk_item(CMD_STEP));    // step with nothing loaded
		queue_line(-32768, -32768, -1, -1, 255, 0);     // fully left and above
		queue_line(32767, 32767, 640, 480, 0, 0);       // ends just past the far corner
		queue_line(5, 5, 5, 5, 7, 1);                   // single point, no major length
		queue_line(0, 0, 3, 1, 255, 4);                 // shallow, walked one past the end
		queue_line(10, 0, 8, 5, 0, 2);                  // steep, minor going down, then dropped
		queue_line(-3, 2, 2, 0, 128, 5);                // shallow, left clipped, minor down
		queue_line(636, 479, 641, 478, 1, 5);           // crosses the right edge on the row above the last
		fill_random(200);
		drain();

		run_phase(-20, -10, 64, 48, 3, 220);
		// oversized window and widest pad, deep rows wrap the offset
		run_phase(-32768, -32768, 16'hFFFF, 16'h1FFF, 16'hFFFF, 220);
		run_phase(100, 200, 16, 16, 0, 200);
		// zero width rejects everything; unused register slots get poked here too
		for (int i = int'(REG_ROW_PAD) + 1; i < (1 << CFG_IDX_BITS); i++)
			write_reg(CFG_IDX_BITS'(i), CFG_BITS'($urandom));
		run_phase(0, 0, 0, 480, 5, 40);
		run_phase(0, 0, 640, 0, 5, 40);
		// window pinned at the largest coordinates
		run_phase(32767, 32767, 4096, 4096, 0, 150);
		run_phase(-300, 50, 4096, 1, 17, 150);
		run_phase(0, 0, 640, 480, 0, 200);

		repeat (10) @(posedge clk);
		if (fault_count == 0 && expected_spans.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
